### src/tsrr_pkg.sv
// Shared types and codes for the task slot round-robin scheduler.
`default_nettype none

package tsrr_pkg;

    // Default sizes.
    localparam int DEF_SLOTS     = 16;
    localparam int DEF_TIME_BITS = 32;

    // Fixed field widths of the item and result ports.
    localparam int ACTION_W = 3;
    localparam int TARGET_W = 4;
    localparam int TICKS_W  = 32;
    localparam int NOW_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CHOSEN_W = 4;

    // Per-slot task state.
    typedef logic [2:0] t_slot_st;

    localparam t_slot_st SLOT_UNUSED   = 3'd0;
    localparam t_slot_st SLOT_RUNNABLE = 3'd1;
    localparam t_slot_st SLOT_RUNNING  = 3'd2;
    localparam t_slot_st SLOT_SLEEPING = 3'd3;
    localparam t_slot_st SLOT_DEAD     = 3'd4;

    // Event codes.
    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_CREATE   = 3'd0;
    localparam t_action ACT_KILL     = 3'd1;
    localparam t_action ACT_CHECK    = 3'd2;
    localparam t_action ACT_SLEEP    = 3'd3;
    localparam t_action ACT_EXIT     = 3'd4;
    localparam t_action ACT_YIELD    = 3'd5;
    localparam t_action ACT_DISPATCH = 3'd6;

    // Result status codes.
    typedef logic [STATUS_W-1:0] t_result;

    localparam t_result RES_DONE          = 3'd0;
    localparam t_result RES_ABSENT        = 3'd1;
    localparam t_result RES_NONE_RUNNABLE = 3'd2;
    localparam t_result RES_EMPTY         = 3'd3;
    localparam t_result RES_NO_TASK       = 3'd4;

    // Port enables of the slot memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

### src/tsrr_slot_mem.sv
// Slot table memory: task state and wake time per slot, with per-entry valid bits.
`default_nettype none

module tsrr_slot_mem
    import tsrr_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int TIME_BITS = DEF_TIME_BITS,
    localparam int SW       = $clog2(SLOTS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mem_ctl             i_ctl,
    input  wire logic [SW-1:0]        i_rd_addr,
    input  wire logic [SW-1:0]        i_wr_addr,
    input  wire t_slot_st             i_wr_status,
    input  wire logic [TIME_BITS-1:0] i_wr_wake,
    output t_slot_st                  o_rd_status,
    output logic [TIME_BITS-1:0]      o_rd_wake
);

    localparam int WORD_W = TIME_BITS + 3;

    logic [WORD_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]  r_vld;
    logic [WORD_W-1:0] r_rd_word;
    logic              r_rd_vld;

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_status, i_wr_wake};
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // Valid bits: an entry never written reads as an unused slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_status = r_rd_vld ? r_rd_word[WORD_W-1:TIME_BITS] : SLOT_UNUSED;
    assign o_rd_wake   = r_rd_word[TIME_BITS-1:0];

endmodule

`default_nettype wire

### src/task_slot_round_robin_scheduler.sv
// Top level of the task slot round-robin scheduler: event sequencer around the slot memory.
`default_nettype none

// The block takes one scheduling event at a time and returns one result for each.
// All slot state lives in a slot memory with one read port and one write port and a
// registered read, so create and dispatch walk the table one slot per cycle, ending early
// at the slot they pick. A kill that hits another slot while a task runs also requeues
// the running task. The input stalls while an event is in work; a finished result sits
// in an output register, and the next event waits only if that register is still full
// when its own result is ready. Right after reset every slot reads as unused; no clearing
// pass is needed.
module task_slot_round_robin_scheduler
    import tsrr_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [TARGET_W-1:0] i_target_slot,
    input  wire logic [TICKS_W-1:0]  i_sleep_ticks,
    input  wire logic [NOW_W-1:0]    i_time_now,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [CHOSEN_W-1:0]      o_chosen_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOT_COUNT = CW'(SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_YIELD = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
    endfunction

    // Control registers.
    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_run_slot, n_run_slot;
    logic          r_run_vld, n_run_vld;
    logic [SW-1:0] r_scan_pos, n_scan_pos;
    logic [SW-1:0] r_rd_addr, n_rd_addr;
    logic [SW-1:0] r_ev_addr, n_ev_addr;
    logic [CW-1:0] r_iss, n_iss;
    logic          r_rv, n_rv;
    logic          r_any, n_any;
    logic          r_out_valid, n_out_valid;

    // Payload registers.
    t_action              r_action, n_action;
    logic [TARGET_W-1:0]  r_target, n_target;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [TIME_BITS-1:0] r_wake_new, n_wake_new;
    t_result              r_res_status, n_res_status;
    logic [CHOSEN_W-1:0]  r_res_chosen, n_res_chosen;
    t_result              r_out_status, n_out_status;
    logic [CHOSEN_W-1:0]  r_out_chosen, n_out_chosen;

    // Slot memory ports.
    t_mem_ctl             mem_ctl;
    logic [SW-1:0]        rd_addr;
    logic [SW-1:0]        wr_addr;
    t_slot_st             wr_status;
    logic [TIME_BITS-1:0] wr_wake;
    t_slot_st             rd_status;
    logic [TIME_BITS-1:0] rd_wake;

    logic          target_ok;
    logic [SW-1:0] tgt_addr;
    logic          iss_done;
    logic          woke;
    logic          live;
    logic [SW-1:0] run_next;

    tsrr_slot_mem #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_status (wr_status),
        .i_wr_wake   (wr_wake),
        .o_rd_status (rd_status),
        .o_rd_wake   (rd_wake)
    );

    // Decode helpers for the event in work and the slot under evaluation.
    assign target_ok = (32'(r_target) < 32'(SLOTS));
    assign tgt_addr  = SW'(r_target);
    assign iss_done  = (r_iss == SLOT_COUNT);
    assign woke      = (rd_status == SLOT_SLEEPING) && (r_time >= rd_wake);
    assign live      = (rd_status != SLOT_UNUSED) && (rd_status != SLOT_DEAD);
    assign run_next  = next_slot(r_run_slot);

    // Event sequencer.
    always_comb begin
        n_state      = r_state;
        n_run_slot   = r_run_slot;
        n_run_vld    = r_run_vld;
        n_scan_pos   = r_scan_pos;
        n_rd_addr    = r_rd_addr;
        n_ev_addr    = r_ev_addr;
        n_iss        = r_iss;
        n_rv         = r_rv;
        n_any        = r_any;
        n_out_valid  = r_out_valid;
        n_action     = r_action;
        n_target     = r_target;
        n_time       = r_time;
        n_wake_new   = r_wake_new;
        n_res_status = r_res_status;
        n_res_chosen = r_res_chosen;
        n_out_status = r_out_status;
        n_out_chosen = r_out_chosen;
        mem_ctl      = '0;
        rd_addr      = r_rd_addr;
        wr_addr      = r_run_slot;
        wr_status    = SLOT_RUNNABLE;
        wr_wake      = r_wake_new;

        // The output register empties on a transfer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action   = i_action;
                    n_target   = i_target_slot;
                    n_time     = TIME_BITS'(i_time_now);
                    n_wake_new = TIME_BITS'(i_time_now) + TIME_BITS'(i_sleep_ticks);
                    n_state    = S_EXEC;
                end
            end

            S_EXEC: begin
                n_rv         = 1'b0;
                n_iss        = '0;
                n_any        = 1'b0;
                n_res_status = RES_DONE;
                n_res_chosen = '0;
                n_state      = S_DONE;
                unique case (r_action)
                    ACT_CREATE: begin
                        n_rd_addr = '0;
                        n_state   = S_SCAN;
                    end
                    ACT_KILL, ACT_CHECK: begin
                        if (!target_ok) begin
                            n_res_status = RES_ABSENT;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = tgt_addr;
                            n_state       = S_CHECK;
                        end
                    end
                    ACT_SLEEP, ACT_EXIT, ACT_YIELD: begin
                        if (!r_run_vld) begin
                            n_res_status = RES_NO_TASK;
                        end else begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = r_run_slot;
                            if (r_action == ACT_SLEEP) begin
                                wr_status = SLOT_SLEEPING;
                            end else if (r_action == ACT_EXIT) begin
                                wr_status = SLOT_DEAD;
                            end else begin
                                wr_status = SLOT_RUNNABLE;
                            end
                            n_run_vld  = 1'b0;
                            n_run_slot = '0;
                        end
                    end
                    ACT_DISPATCH: begin
                        // The running task goes back to runnable before the scan.
                        if (r_run_vld) begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = r_run_slot;
                            wr_status     = SLOT_RUNNABLE;
                            n_run_vld     = 1'b0;
                            n_run_slot    = '0;
                        end
                        n_rd_addr = r_scan_pos;
                        n_state   = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end

            S_CHECK: begin
                n_state = S_DONE;
                if (rd_status == SLOT_UNUSED) begin
                    n_res_status = RES_ABSENT;
                end else if (r_action == ACT_KILL) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = tgt_addr;
                    wr_status     = SLOT_DEAD;
                    if (r_run_vld && (r_run_slot != tgt_addr)) begin
                        n_state = S_YIELD;
                    end else begin
                        n_run_vld  = 1'b0;
                        n_run_slot = '0;
                    end
                end
            end

            S_YIELD: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = r_run_slot;
                wr_status     = SLOT_RUNNABLE;
                n_run_vld     = 1'b0;
                n_run_slot    = '0;
                n_state       = S_DONE;
            end

            S_SCAN: begin
                // One slot read issued per cycle; its data is judged in the next cycle.
                if (!iss_done) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = r_rd_addr;
                    n_rd_addr     = next_slot(r_rd_addr);
                    n_iss         = r_iss + CW'(1);
                end
                n_rv      = !iss_done;
                n_ev_addr = r_rd_addr;

                if (r_rv) begin
                    if (r_action == ACT_CREATE) begin
                        if (rd_status == SLOT_UNUSED) begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = r_ev_addr;
                            wr_status     = SLOT_RUNNABLE;
                            wr_wake       = '0;
                            n_res_status  = RES_DONE;
                            n_res_chosen  = CHOSEN_W'(r_ev_addr);
                            n_state       = S_DONE;
                        end else if (iss_done) begin
                            n_res_status = RES_ABSENT;
                            n_state      = S_DONE;
                        end
                    end else if ((rd_status == SLOT_RUNNABLE) || woke) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = r_ev_addr;
                        wr_status     = SLOT_RUNNING;
                        n_run_slot    = r_ev_addr;
                        n_run_vld     = 1'b1;
                        n_scan_pos    = next_slot(r_ev_addr);
                        n_res_status  = RES_DONE;
                        n_res_chosen  = CHOSEN_W'(r_ev_addr);
                        n_state       = S_DONE;
                    end else begin
                        // Dead slots are freed as the scan passes them.
                        if (rd_status == SLOT_DEAD) begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = r_ev_addr;
                            wr_status     = SLOT_UNUSED;
                        end
                        n_any = r_any | live;
                        if (iss_done) begin
                            n_res_status = (r_any | live) ? RES_NONE_RUNNABLE : RES_EMPTY;
                            n_state      = S_DONE;
                        end
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_chosen = r_res_chosen;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_slot  <= '0;
            r_run_vld   <= 1'b0;
            r_scan_pos  <= '0;
            r_rd_addr   <= '0;
            r_ev_addr   <= '0;
            r_iss       <= '0;
            r_rv        <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_slot  <= n_run_slot;
            r_run_vld   <= n_run_vld;
            r_scan_pos  <= n_scan_pos;
            r_rd_addr   <= n_rd_addr;
            r_ev_addr   <= n_ev_addr;
            r_iss       <= n_iss;
            r_rv        <= n_rv;
            r_any       <= n_any;
            r_out_valid <= n_out_valid;
        end
    end

    // Event and result payload.
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_target     <= n_target;
        r_time       <= n_time;
        r_wake_new   <= n_wake_new;
        r_res_status <= n_res_status;
        r_res_chosen <= n_res_chosen;
        r_out_status <= n_out_status;
        r_out_chosen <= n_out_chosen;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_chosen_slot = r_out_chosen;

`ifndef ASSERT_OFF
    // The sequencer never reads and writes the same slot in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en && (rd_addr == wr_addr)))
        else $error("slot memory read and write to the same entry");

    // A running task was the last pick, so the scan resumes just after it.
    a_run_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_vld |-> (r_scan_pos == run_next))
        else $error("scan position out of step with the running slot");

    // A scan never issues more reads than there are slots.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss <= SLOT_COUNT)
        else $error("scan read count beyond table size");
`endif

endmodule

`default_nettype wire
